/* sv/midi_cc_controller_classifier_macros.svh */
// ---------------------------------------------------------------------------
// midi_cc_controller_classifier_macros
// assertion helpers used by the controller classifier rtl
// ---------------------------------------------------------------------------
`ifndef MIDI_CC_CONTROLLER_CLASSIFIER_MACROS_SVH
`define MIDI_CC_CONTROLLER_CLASSIFIER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define CMCC_ASSERT_SAME(lbl, clk, rstn, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define CMCC_ASSERT_NEXT(lbl, clk, rstn, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* sv/cmcc_pkg.sv */
// ---------------------------------------------------------------------------
// cmcc_pkg
// types and constants of the controller classifier
// ---------------------------------------------------------------------------
`default_nettype none

package cmcc_pkg;

    // word kinds on the input channel
    typedef enum logic [1:0] {
        KIND_CC     = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    // controller classes
    typedef enum logic [2:0] {
        CTYPE_UNKNOWN    = 3'd0,
        CTYPE_TOGGLE     = 3'd1,
        CTYPE_MOMENTARY  = 3'd2,
        CTYPE_CONTINUOUS = 3'd3,
        CTYPE_ENDLESS    = 3'd4
    } ctype_t;

    localparam logic [6:0] TOP_VALUE       = 7'd127;
    localparam logic [7:0] NONE_MARK       = 8'hFF;
    localparam logic [3:0] COUNT_MAX       = 4'd15;
    localparam logic [3:0] MOMENTARY_COUNT = 4'd4;
    localparam logic [3:0] TOGGLE_COUNT    = 4'd2;

    // learning state
    typedef struct packed {
        logic [7:0] cc;
        logic [7:0] min;
        logic [7:0] max;
        logic [3:0] count;
        logic [6:0] prev;
        logic       have_prev;
        logic       wrap_down;
        logic       wrap_up;
        logic       interior;
        ctype_t     ctype;
    } learn_state_t;

    localparam learn_state_t LEARN_CLEAR = '{
        cc:        NONE_MARK,
        min:       NONE_MARK,
        max:       NONE_MARK,
        count:     4'd0,
        prev:      7'd0,
        have_prev: 1'b0,
        wrap_down: 1'b0,
        wrap_up:   1'b0,
        interior:  1'b0,
        ctype:     CTYPE_UNKNOWN
    };

    // result word
    typedef struct packed {
        ctype_t     ctype;
        logic [7:0] learned_cc;
        logic [7:0] lowest;
        logic [7:0] highest;
        logic [3:0] count;
    } result_t;

endpackage

`default_nettype wire

/* sv/cmcc_learn.sv */
// ---------------------------------------------------------------------------
// cmcc_learn
// learning state register and its update per accepted word
// ---------------------------------------------------------------------------
`default_nettype none

module cmcc_learn
    import cmcc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic [1:0] kind,
    input  wire logic [6:0] num,
    input  wire logic [6:0] val,
    output result_t         res_next
);

    learn_state_t state_reg;
    learn_state_t state_next;
    learn_state_t upd;

    // state update for one word
    always_comb begin
        learn_state_t base;
        base = state_reg;
        upd  = state_reg;
        unique case (kind)
            KIND_CC: begin
                // another controller number restarts learning
                if (state_reg.have_prev && ({1'b0, num} != state_reg.cc)) begin
                    base = LEARN_CLEAR;
                end
                upd = base;
                if (!base.have_prev) begin
                    upd.count = 4'd1;
                    upd.cc    = {1'b0, num};
                    upd.min   = {1'b0, val};
                    upd.max   = {1'b0, val};
                end else begin
                    if (base.count != COUNT_MAX) begin
                        upd.count = base.count + 4'd1;
                    end
                    if (val == 7'd0) begin
                        if (base.prev == TOP_VALUE) begin
                            upd.wrap_down = 1'b1;
                        end
                    end else if (val == TOP_VALUE) begin
                        if (base.prev == 7'd0) begin
                            upd.wrap_up = 1'b1;
                        end
                    end else begin
                        upd.interior = 1'b1;
                    end
                    if ({1'b0, val} < base.min) begin
                        upd.min = {1'b0, val};
                    end
                    if ({1'b0, val} > base.max) begin
                        upd.max = {1'b0, val};
                    end
                end
                upd.prev      = val;
                upd.have_prev = 1'b1;
            end
            KIND_FINISH: begin
                // classify from count and flags
                if (state_reg.count > MOMENTARY_COUNT) begin
                    upd.ctype = (state_reg.interior &&
                                 (state_reg.wrap_down || state_reg.wrap_up)) ?
                                CTYPE_ENDLESS : CTYPE_CONTINUOUS;
                end else if (state_reg.count == MOMENTARY_COUNT) begin
                    upd.ctype = CTYPE_MOMENTARY;
                end else if (state_reg.count == TOGGLE_COUNT) begin
                    upd.ctype = CTYPE_TOGGLE;
                end else begin
                    upd.ctype = CTYPE_UNKNOWN;
                end
            end
            KIND_CLEAR: begin
                upd = LEARN_CLEAR;
            end
            default: begin
                upd = state_reg;
            end
        endcase
    end

    assign state_next = step_en ? upd : state_reg;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LEARN_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // result word shows the state after the step
    assign res_next = '{
        ctype:      upd.ctype,
        learned_cc: upd.cc,
        lowest:     upd.min,
        highest:    upd.max,
        count:      upd.count
    };

endmodule

`default_nettype wire

/* sv/midi_cc_controller_classifier.sv */
// ---------------------------------------------------------------------------
// midi_cc_controller_classifier
// learns the kind of physical controller behind a control change stream
// ---------------------------------------------------------------------------
// channel  dir  fields
// s_       in   kind, cc_number, cc_value
// m_       out  ctrl_class, learned_cc, lowest_value, highest_value,
//                message_count
//
// one word per cycle while s_ready is high; each accepted word gives one result word in the next cycle,
// set by the single state update between the learning and result registers.
// s_ready is low only while a result word waits and m_ready is low.
// synchronous active-low reset clears learning and empties the result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "midi_cc_controller_classifier_macros.svh"

module midi_cc_controller_classifier
    import cmcc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_kind,
    input  wire logic [6:0] s_cc_number,
    input  wire logic [6:0] s_cc_value,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_ctrl_class,
    output logic [7:0]      m_learned_cc,
    output logic [7:0]      m_lowest_value,
    output logic [7:0]      m_highest_value,
    output logic [3:0]      m_message_count
);

    logic    accept;
    logic    m_valid_reg;
    logic    m_valid_next;
    result_t res_next;
    result_t res_reg;

    // take a word whenever the result register is free or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    cmcc_learn u_learn (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (accept),
        .kind     (s_kind),
        .num      (s_cc_number),
        .val      (s_cc_value),
        .res_next (res_next)
    );

    // result register
    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ctrl_class    = res_reg.ctype;
    assign m_learned_cc    = res_reg.learned_cc;
    assign m_lowest_value  = res_reg.lowest;
    assign m_highest_value = res_reg.highest;
    assign m_message_count = res_reg.count;

    // checks
    `CMCC_ASSERT_SAME(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready, "input taken while result stalled")
    `CMCC_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, s_valid && s_ready, m_valid, "accepted word gave no result")
    `CMCC_ASSERT_SAME(a_count_matches_cc, aclk, aresetn, m_valid, (m_learned_cc == NONE_MARK) == (m_message_count == 4'd0), "count and learned number disagree")
    `CMCC_ASSERT_SAME(a_min_not_above_max, aclk, aresetn, m_valid && (m_message_count != 4'd0), m_lowest_value <= m_highest_value, "lowest above highest")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the midi control change controller classifier
// ---------------------------------------------------------------------------
// a short table of hand-picked words walks learning through every controller
// class, a change of controller number, clear and the unused kind. Random
// bursts that look like real controllers follow: buttons, knobs, endless
// encoders, all with random numbers and values, plus some stray words. Each
// accepted input word is run through a local model of the learning state and
// the expected result word is queued. Each accepted result word is compared
// field by field with the oldest queued one. Both channels idle at random over
// several phases, and once the output side holds off long enough to stall the
// input.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top
    import cmcc_pkg::*;
();

    // kind code with no meaning, must leave the state alone
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         CLK_HALF    = 6;
    localparam int         RANDOM_WORDS = 1900;

    typedef struct packed {
        ctype_t     ctype;
        logic [7:0] learned_cc;
        logic [7:0] lowest;
        logic [7:0] highest;
        logic [3:0] count;
    } cc_result_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] number;
        logic [6:0] value;
        bit         typed;
        cc_result_t want;
    } probe_row_t;

    localparam cc_result_t NO_CHECK = '{CTYPE_UNKNOWN, 8'd0, 8'd0, 8'd0, 4'd0};
    localparam cc_result_t BLANK    = '{CTYPE_UNKNOWN, NONE_MARK, NONE_MARK,
                                        NONE_MARK, 4'd0};

    // hand-picked words, expected result typed in where it is obvious
    localparam int PROBE_COUNT = 25;
    localparam probe_row_t PROBES [PROBE_COUNT] = '{
        '{KIND_CLEAR,  7'd0,   7'd0,   1'b1, BLANK},
        '{KIND_UNUSED, 7'd127, 7'd127, 1'b1, BLANK},
        '{KIND_FINISH, 7'd0,   7'd0,   1'b1, BLANK},
        '{KIND_CC,     7'd127, 7'd127, 1'b1,
          '{CTYPE_UNKNOWN, 8'd127, 8'd127, 8'd127, 4'd1}},
        '{KIND_CC,     7'd127, 7'd0,   1'b1,
          '{CTYPE_UNKNOWN, 8'd127, 8'd0, 8'd127, 4'd2}},
        '{KIND_FINISH, 7'd0,   7'd0,   1'b1,
          '{CTYPE_TOGGLE, 8'd127, 8'd0, 8'd127, 4'd2}},
        '{KIND_CC,     7'd127, 7'd127, 1'b0, NO_CHECK},
        '{KIND_CC,     7'd127, 7'd64,  1'b0, NO_CHECK},
        '{KIND_FINISH, 7'd0,   7'd0,   1'b1,
          '{CTYPE_MOMENTARY, 8'd127, 8'd0, 8'd127, 4'd4}},
        '{KIND_CC,     7'd127, 7'd1,   1'b0, NO_CHECK},
        '{KIND_FINISH, 7'd127, 7'd127, 1'b1,
          '{CTYPE_ENDLESS, 8'd127, 8'd0, 8'd127, 4'd5}},
        '{KIND_CC,     7'd0,   7'd0,   1'b1,
          '{CTYPE_UNKNOWN, 8'd0, 8'd0, 8'd0, 4'd1}},
        '{KIND_CC,     7'd0,   7'd127, 1'b0, NO_CHECK},
        '{KIND_CC,     7'd0,   7'd0,   1'b0, NO_CHECK},
        '{KIND_CC,     7'd0,   7'd127, 1'b0, NO_CHECK},
        '{KIND_CC,     7'd0,   7'd0,   1'b0, NO_CHECK},
        '{KIND_FINISH, 7'd0,   7'd0,   1'b1,
          '{CTYPE_CONTINUOUS, 8'd0, 8'd0, 8'd127, 4'd5}},
        '{KIND_CC,     7'd0,   7'd85,  1'b0, NO_CHECK},
        '{KIND_CC,     7'd0,   7'd42,  1'b0, NO_CHECK},
        '{KIND_FINISH, 7'd0,   7'd0,   1'b0, NO_CHECK},
        '{KIND_CC,     7'd42,  7'd3,   1'b1,
          '{CTYPE_UNKNOWN, 8'd42, 8'd3, 8'd3, 4'd1}},
        '{KIND_FINISH, 7'd0,   7'd0,   1'b0, NO_CHECK},
        '{KIND_CC,     7'd42,  7'd3,   1'b0, NO_CHECK},
        '{KIND_UNUSED, 7'd85,  7'd42,  1'b0, NO_CHECK},
        '{KIND_FINISH, 7'd0,   7'd0,   1'b0, NO_CHECK}
    };

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_kind;
    logic [6:0] s_cc_number;
    logic [6:0] s_cc_value;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_ctrl_class;
    logic [7:0] m_learned_cc;
    logic [7:0] m_lowest_value;
    logic [7:0] m_highest_value;
    logic [3:0] m_message_count;

    // learning state of the local model
    logic [7:0] lrn_cc;
    logic [7:0] lrn_min;
    logic [7:0] lrn_max;
    logic [3:0] lrn_count;
    logic [6:0] lrn_prev;
    bit         lrn_have_prev;
    bit         lrn_wrap_down;
    bit         lrn_wrap_up;
    bit         lrn_interior;
    ctype_t     lrn_type;

    cc_result_t pending_results [$];
    int         err_count = 0;
    int         words_sent;
    int         tx_idle_pct;
    int         rx_stall_pct;
    bit         rx_hold;

    midi_cc_controller_classifier dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_cc_number       (s_cc_number),
        .s_cc_value        (s_cc_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ctrl_class      (m_ctrl_class),
        .m_learned_cc      (m_learned_cc),
        .m_lowest_value    (m_lowest_value),
        .m_highest_value   (m_highest_value),
        .m_message_count   (m_message_count)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // forget everything learnt so far
    function automatic void forget_controller();
        lrn_cc        = NONE_MARK;
        lrn_min       = NONE_MARK;
        lrn_max       = NONE_MARK;
        lrn_count     = 4'd0;
        lrn_prev      = 7'd0;
        lrn_have_prev = 1'b0;
        lrn_wrap_down = 1'b0;
        lrn_wrap_up   = 1'b0;
        lrn_interior  = 1'b0;
        lrn_type      = CTYPE_UNKNOWN;
    endfunction

    // advance the learning state by one word and give the result word
    function automatic cc_result_t learn_step(logic [1:0] kind, logic [6:0] number,
                                              logic [6:0] value);
        case (kind)
            KIND_CC: begin
                // another controller restarts learning
                if (lrn_have_prev && {1'b0, number} != lrn_cc)
                    forget_controller();
                if (!lrn_have_prev) begin
                    lrn_count = 4'd1;
                    lrn_cc    = {1'b0, number};
                    lrn_min   = {1'b0, value};
                    lrn_max   = {1'b0, value};
                end else begin
                    if (lrn_count < COUNT_MAX)
                        lrn_count = lrn_count + 4'd1;
                    if (value == 7'd0) begin
                        if (lrn_prev == TOP_VALUE)
                            lrn_wrap_down = 1'b1;
                    end else if (value == TOP_VALUE) begin
                        if (lrn_prev == 7'd0)
                            lrn_wrap_up = 1'b1;
                    end else begin
                        lrn_interior = 1'b1;
                    end
                    if ({1'b0, value} < lrn_min)
                        lrn_min = {1'b0, value};
                    if ({1'b0, value} > lrn_max)
                        lrn_max = {1'b0, value};
                end
                lrn_prev      = value;
                lrn_have_prev = 1'b1;
            end
            KIND_FINISH: begin
                if (lrn_count > MOMENTARY_COUNT)
                    lrn_type = (lrn_interior && (lrn_wrap_down || lrn_wrap_up)) ?
                               CTYPE_ENDLESS : CTYPE_CONTINUOUS;
                else if (lrn_count == MOMENTARY_COUNT)
                    lrn_type = CTYPE_MOMENTARY;
                else if (lrn_count == TOGGLE_COUNT)
                    lrn_type = CTYPE_TOGGLE;
                else
                    lrn_type = CTYPE_UNKNOWN;
            end
            KIND_CLEAR: forget_controller();
            default: ;
        endcase
        return '{lrn_type, lrn_cc, lrn_min, lrn_max, lrn_count};
    endfunction

    // offer one word, wait for it to be taken and queue its result
    task automatic send_word(logic [1:0] kind, logic [6:0] number, logic [6:0] value,
                             bit typed = 1'b0, cc_result_t typed_want = NO_CHECK);
        int         gap;
        cc_result_t want;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_cc_number <= number;
        s_cc_value  <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        want = learn_step(kind, number, value);
        pending_results.push_back(typed ? typed_want : want);
        words_sent++;
    endtask

    // a burst from one controller, usually closed by a finish
    task automatic send_burst();
        logic [6:0] number;
        logic [6:0] value;
        int         len;
        int         style;
        bit         falling;
        number  = 7'($urandom_range(127));
        len     = $urandom_range(1, 18);
        style   = $urandom_range(3);
        falling = 1'($urandom_range(1));
        value   = falling ? 7'($urandom_range(7)) : 7'($urandom_range(127, 120));
        for (int i = 0; i < len; i++) begin
            case (style)
                // button: only the two end values
                0: value = $urandom_range(1) ? TOP_VALUE : 7'd0;
                // knob: anywhere
                1: value = 7'($urandom_range(127));
                // endless encoder: single steps that roll over
                2: value = falling ? value - 7'd1 : value + 7'd1;
                // near the ends
                default: value = 7'($urandom_range(1) ? $urandom_range(127, 125) :
                                                        $urandom_range(2));
            endcase
            send_word(KIND_CC, number, value);
        end
        if ($urandom_range(99) < 85)
            send_word(KIND_FINISH, 7'($urandom_range(127)), 7'($urandom_range(127)));
        if ($urandom_range(99) < 15)
            send_word(KIND_CLEAR, 7'($urandom_range(127)), 7'($urandom_range(127)));
    endtask

    // random words for one idling phase
    task automatic run_phase(int tx_pct, int rx_pct, int word_goal);
        int target;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        target       = words_sent + word_goal;
        while (words_sent < target) begin
            if ($urandom_range(99) < 80)
                send_burst();
            else
                send_word(2'($urandom_range(3)), 7'($urandom_range(127)),
                          7'($urandom_range(127)));
        end
    endtask

    // output side: check each result word taken, then pick the next ready
    always @(posedge aclk) begin
        cc_result_t got;
        cc_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got = '{ctype_t'(m_ctrl_class), m_learned_cc, m_lowest_value,
                    m_highest_value, m_message_count};
            if (pending_results.size() == 0) begin
                $error("result word with none expected");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.ctype !== want.ctype) begin
                    $error("ctrl_class expected %0d got %0d", want.ctype, got.ctype);
                    err_count++;
                end
                if (got.learned_cc !== want.learned_cc) begin
                    $error("learned_cc expected %0d got %0d",
                           want.learned_cc, got.learned_cc);
                    err_count++;
                end
                if (got.lowest !== want.lowest) begin
                    $error("lowest_value expected %0d got %0d", want.lowest, got.lowest);
                    err_count++;
                end
                if (got.highest !== want.highest) begin
                    $error("highest_value expected %0d got %0d",
                           want.highest, got.highest);
                    err_count++;
                end
                if (got.count !== want.count) begin
                    $error("message_count expected %0d got %0d", want.count, got.count);
                    err_count++;
                end
            end
        end
        m_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog
    initial begin
        #(2 * CLK_HALF * 400000);
        $display("Verification failed");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_kind       = KIND_CC;
        s_cc_number  = 7'd0;
        s_cc_value   = 7'd0;
        rx_hold      = 1'b0;
        words_sent   = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        forget_controller();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // hand-picked words
        for (int i = 0; i < PROBE_COUNT; i++)
            send_word(PROBES[i].kind, PROBES[i].number, PROBES[i].value,
                      PROBES[i].typed, PROBES[i].want);

        // output held off for a long stretch while words keep coming
        fork
            begin
                rx_hold <= 1'b1;
                repeat (200) @(posedge aclk);
                rx_hold <= 1'b0;
            end
            run_phase(0, 0, 40);
        join

        run_phase(0, 0, RANDOM_WORDS / 4);
        run_phase(52, 0, RANDOM_WORDS / 4);
        run_phase(0, 52, RANDOM_WORDS / 4);
        run_phase(8, 8, RANDOM_WORDS / 4);

        // drain
        s_valid      <= 1'b0;
        rx_stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
